@@ rtl/core/crp_pkg.sv @@
// crp_pkg: shared types and constants of the credential record parser
// no dependencies; used by every module of the parser
`timescale 1ns / 1ps

package crp_pkg;

    // one input beat: a record byte and its end-of-record flag
    typedef struct packed {
        logic [7:0] record_byte;
        logic       is_last;
    } crp_in_t;

    // one result beat: a field byte or an end-of-record summary
    typedef struct packed {
        logic        result_kind;
        logic [1:0]  field_select;
        logic [7:0]  payload_byte;
        logic        record_status;
        logic [31:0] sign_counter;
        logic [6:0]  user_id_length;
    } crp_out_t;

    // up to two results caused by one input beat, payload first
    typedef struct packed {
        logic     pay_valid;
        crp_out_t pay;
        logic     sum_valid;
        crp_out_t sum;
    } crp_emit_t;

    // record layout
    localparam logic [31:0] RECORD_MAGIC   = 32'h3144_4946;
    localparam logic [7:0]  RECORD_VERSION = 8'd1;
    localparam logic [6:0]  MIN_RECORD     = 7'd77;
    localparam logic [6:0]  HEADER_LAST    = 7'd73;
    localparam logic [6:0]  VERSION_POS    = 7'd4;
    localparam logic [6:0]  COUNT_FIRST    = 7'd6;
    localparam logic [6:0]  COUNT_LAST     = 7'd9;

    // parse phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LEN0   = 3'd1;
    localparam logic [2:0] PH_FLD0   = 3'd2;
    localparam logic [2:0] PH_LEN1   = 3'd3;
    localparam logic [2:0] PH_FLD1   = 3'd4;
    localparam logic [2:0] PH_LEN2   = 3'd5;
    localparam logic [2:0] PH_FLD2   = 3'd6;
    localparam logic [2:0] PH_TRAIL  = 3'd7;

    // result codes
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_BAD   = 1'b1;

    // result queue geometry
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = 2;
    localparam int unsigned LEVEL_W    = 3;

endpackage

@@ rtl/core/crp_stream_if.sv @@
// crp_stream_if: valid/ready channel carrying one payload struct per beat
// payload type is set per instance, normally from crp_pkg
`timescale 1ns / 1ps

interface crp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

@@ rtl/core/crp_parse_core.sv @@
// crp_parse_core: record parse state and per-byte result logic
// depends on crp_pkg
`timescale 1ns / 1ps

module crp_parse_core
    import crp_pkg::*;
#(
    parameter int unsigned PARTY_NAME_MAX = 64,
    parameter int unsigned USER_NAME_MAX  = 64,
    parameter int unsigned USER_ID_MAX    = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  crp_in_t   item,
    output crp_emit_t emit
);

    logic [6:0]  pos_reg,   pos_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  rem_reg,   rem_next;
    logic [31:0] count_reg, count_next;
    logic        err_reg,   err_next;
    logic [6:0]  idc_reg,   idc_next;

    logic [7:0]  b;
    logic [1:0]  count_lane;
    logic        len_bad;
    logic [7:0]  rem_dec;
    logic        sum_bad;

    assign b          = item.record_byte;
    assign count_lane = 2'(pos_reg - COUNT_FIRST);

    // bound check of the length byte for the current field
    always_comb
    begin
        unique case (phase_reg)
            PH_LEN0: len_bad = (b >= 8'(PARTY_NAME_MAX));
            PH_LEN1: len_bad = (b >= 8'(USER_NAME_MAX));
            default: len_bad = (b > 8'(USER_ID_MAX));
        endcase
    end

    assign rem_dec = (rem_reg != 8'd0) ? rem_reg - 8'd1 : rem_reg;

    // next state and results for one accepted byte
    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        err_next   = err_reg;
        idc_next   = idc_reg;
        emit       = '0;
        sum_bad    = 1'b0;
        if (fire)
        begin
            if (pos_reg < MIN_RECORD)
            begin
                pos_next = pos_reg + 7'd1;
            end
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg < VERSION_POS)
                    begin
                        if (b != RECORD_MAGIC[{pos_reg[1:0], 3'b000} +: 8])
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (pos_reg == VERSION_POS)
                    begin
                        if (b != RECORD_VERSION)
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (pos_reg >= COUNT_FIRST && pos_reg <= COUNT_LAST)
                    begin
                        count_next = count_reg | (32'(b) << {count_lane, 3'b000});
                    end
                    if (pos_reg >= HEADER_LAST)
                    begin
                        phase_next = PH_LEN0;
                    end
                end
                PH_LEN0, PH_LEN1, PH_LEN2:
                begin
                    if (phase_reg == PH_LEN2)
                    begin
                        idc_next = b[6:0];
                    end
                    if (len_bad)
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_TRAIL;
                    end
                    else
                    begin
                        rem_next   = b;
                        phase_next = (b == 8'd0) ? phase_reg + 3'd2 : phase_reg + 3'd1;
                    end
                end
                PH_FLD0, PH_FLD1, PH_FLD2:
                begin
                    if (!err_reg)
                    begin
                        emit.pay_valid        = 1'b1;
                        emit.pay.result_kind  = KIND_PAYLOAD;
                        emit.pay.field_select = 2'((phase_reg - PH_FLD0) >> 1);
                        emit.pay.payload_byte = b;
                    end
                    rem_next = rem_dec;
                    if (rem_dec == 8'd0)
                    begin
                        phase_next = phase_reg + 3'd1;
                    end
                end
                default:
                begin
                    // trailing bytes are ignored
                end
            endcase

            // end of record: summary, then back to the header phase
            if (item.is_last)
            begin
                sum_bad = err_next || (pos_next < MIN_RECORD) || (phase_next != PH_TRAIL);
                emit.sum_valid          = 1'b1;
                emit.sum.result_kind    = KIND_SUMMARY;
                emit.sum.record_status  = sum_bad ? STATUS_BAD : STATUS_OK;
                emit.sum.sign_counter   = sum_bad ? 32'd0 : count_next;
                emit.sum.user_id_length = sum_bad ? 7'd0 : idc_next;
                pos_next   = '0;
                phase_next = PH_HEADER;
                rem_next   = '0;
                count_next = '0;
                err_next   = 1'b0;
                idc_next   = '0;
            end
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_HEADER;
            rem_reg   <= '0;
            count_reg <= '0;
            err_reg   <= 1'b0;
            idc_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            idc_reg   <= idc_next;
        end
    end

endmodule

@@ rtl/core/crp_result_fifo.sv @@
// crp_result_fifo: small result queue taking up to two beats per cycle
// depends on crp_pkg
`timescale 1ns / 1ps

module crp_result_fifo
    import crp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  crp_emit_t          emit,
    input  logic               pop,
    output logic               not_empty,
    output crp_out_t           head,
    output logic [LEVEL_W-1:0] level
);

    crp_out_t           slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg,  level_next;
    logic [PTR_W-1:0]   sum_slot;
    logic [1:0]         push_cnt;

    // summary goes behind the payload beat of the same byte
    assign sum_slot = wr_ptr_reg + PTR_W'(emit.pay_valid);
    assign push_cnt = 2'(emit.pay_valid) + 2'(emit.sum_valid);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign level_next  = level_reg + LEVEL_W'(push_cnt) - LEVEL_W'(pop);

    assign not_empty = (level_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign level     = level_reg;

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (emit.pay_valid)
        begin
            slot_reg[wr_ptr_reg] <= emit.pay;
        end
        if (emit.sum_valid)
        begin
            slot_reg[sum_slot] <= emit.sum;
        end
    end

endmodule

@@ rtl/core/credential_record_parser.sv @@
// credential_record_parser: top level of the streaming credential record parser
// depends on crp_pkg, crp_stream_if, crp_parse_core and crp_result_fifo
`timescale 1ns / 1ps

// Accepts one record byte per cycle and returns field bytes and one summary
// per record. A byte is registered on entry, parsed once the result queue has
// room for two beats, and its results land in a four-entry result queue. The
// input takes a new byte every cycle as long as the queue drains one beat per
// cycle; the last byte of a record that is a field byte can cause two beats,
// and the queue level then sets when the input stalls.
// Payload beats of a record whose summary reports malformed must be dropped
// by the consumer.
module credential_record_parser
    import crp_pkg::*;
#(
    parameter int unsigned PARTY_NAME_MAX = 64,
    parameter int unsigned USER_NAME_MAX  = 64,
    parameter int unsigned USER_ID_MAX    = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    crp_stream_if.sink    byte_stream,
    crp_stream_if.source  result_stream
);

    logic               stage_valid_reg, stage_valid_next;
    crp_in_t            stage_item_reg;
    logic               stage_fire;
    logic               in_fire;
    crp_emit_t          emit;
    logic [LEVEL_W-1:0] fifo_level;
    logic               fifo_not_empty;
    crp_out_t           fifo_head;

    // the staged byte moves on once the queue has room for two beats
    assign stage_fire        = stage_valid_reg && (fifo_level <= LEVEL_W'(FIFO_DEPTH - 2));
    assign byte_stream.ready = !stage_valid_reg || stage_fire;
    assign in_fire           = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        priority if (in_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_fire)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_item_reg <= byte_stream.payload;
        end
    end

    crp_parse_core #(
        .PARTY_NAME_MAX (PARTY_NAME_MAX),
        .USER_NAME_MAX  (USER_NAME_MAX),
        .USER_ID_MAX    (USER_ID_MAX)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (stage_fire),
        .item  (stage_item_reg),
        .emit  (emit)
    );

    crp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .pop       (result_stream.valid && result_stream.ready),
        .not_empty (fifo_not_empty),
        .head      (fifo_head),
        .level     (fifo_level)
    );

    // output channel
    assign result_stream.valid   = fifo_not_empty;
    assign result_stream.payload = fifo_head;

    // result queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_level <= LEVEL_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // a byte held in the input stage is not lost
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !stage_fire |=> stage_valid_reg)
        else $error("staged byte dropped");

    // a malformed summary carries no count or length
    assert property (@(posedge clk) disable iff (!rst_n)
        result_stream.valid && result_stream.payload.result_kind == KIND_SUMMARY &&
        result_stream.payload.record_status == STATUS_BAD |->
        result_stream.payload.sign_counter == 32'd0 &&
        result_stream.payload.user_id_length == 7'd0)
        else $error("malformed summary with nonzero fields");

endmodule

@@ sim/crp_tb_checker.sv @@
// crp_tb_checker: watches both channels of the credential record parser,
// predicts every result beat and compares it with what the block returns
// depends on crp_pkg
`timescale 1ns / 1ps

module crp_tb_checker
    import crp_pkg::*;
#(
    parameter int unsigned PARTY_NAME_MAX = 64,
    parameter int unsigned USER_NAME_MAX  = 64,
    parameter int unsigned USER_ID_MAX    = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    input  logic     byte_ready,
    input  crp_in_t  byte_beat,
    input  logic     result_valid,
    input  logic     result_ready,
    input  crp_out_t result_beat,
    output int       mismatch_count,
    output int       pending_results
);

    // parser state as the block should hold it
    logic [6:0]  rec_pos    = '0;
    logic [2:0]  rec_phase  = PH_HEADER;
    logic [7:0]  field_left = '0;
    logic [31:0] sign_word  = '0;
    logic        rec_bad    = 1'b0;
    logic [6:0]  id_len     = '0;

    // result beats still owed by the block, oldest first
    crp_out_t owed_results[$];
    crp_out_t want;

    initial
    begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    // back to the start of a record
    function automatic void clear_record();
        rec_pos    = '0;
        rec_phase  = PH_HEADER;
        field_left = '0;
        sign_word  = '0;
        rec_bad    = 1'b0;
        id_len     = '0;
    endfunction

    // advance the parser by one byte and queue the beats it causes
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        logic [6:0]  pos;
        logic [31:0] magic_word;
        logic [2:0]  sel_code;
        logic        len_bad;
        crp_out_t    beat;
        pos        = rec_pos;
        magic_word = RECORD_MAGIC >> (8 * pos);
        if (rec_pos < MIN_RECORD)
        begin
            rec_pos = rec_pos + 7'd1;
        end

        case (rec_phase)
            PH_HEADER:
            begin
                if (pos < VERSION_POS)
                begin
                    if (b != magic_word[7:0])
                    begin
                        rec_bad = 1'b1;
                    end
                end
                else if (pos == VERSION_POS)
                begin
                    if (b != RECORD_VERSION)
                    begin
                        rec_bad = 1'b1;
                    end
                end
                else if (pos >= COUNT_FIRST && pos <= COUNT_LAST)
                begin
                    sign_word = sign_word | ({24'd0, b} << (8 * (pos - COUNT_FIRST)));
                end
                if (pos >= HEADER_LAST)
                begin
                    rec_phase = PH_LEN0;
                end
            end
            PH_LEN0, PH_LEN1, PH_LEN2:
            begin
                // names must stay below their bound, the identifier may reach it
                if (rec_phase == PH_LEN0)
                begin
                    len_bad = b >= PARTY_NAME_MAX;
                end
                else if (rec_phase == PH_LEN1)
                begin
                    len_bad = b >= USER_NAME_MAX;
                end
                else
                begin
                    len_bad = b > USER_ID_MAX;
                    id_len  = b[6:0];
                end
                if (len_bad)
                begin
                    rec_bad   = 1'b1;
                    rec_phase = PH_TRAIL;
                end
                else
                begin
                    field_left = b;
                    rec_phase  = (b == 8'd0) ? rec_phase + 3'd2 : rec_phase + 3'd1;
                end
            end
            PH_FLD0, PH_FLD1, PH_FLD2:
            begin
                // field bytes pass through unless the record is already bad
                if (!rec_bad)
                begin
                    sel_code          = rec_phase - PH_FLD0;
                    beat              = '0;
                    beat.result_kind  = KIND_PAYLOAD;
                    beat.field_select = sel_code[2:1];
                    beat.payload_byte = b;
                    owed_results.push_back(beat);
                end
                if (field_left > 8'd0)
                begin
                    field_left = field_left - 8'd1;
                end
                if (field_left == 8'd0)
                begin
                    rec_phase = rec_phase + 3'd1;
                end
            end
            default:
            begin
            end
        endcase

        // end of record summary
        if (last)
        begin
            beat             = '0;
            beat.result_kind = KIND_SUMMARY;
            if (rec_bad || rec_pos < MIN_RECORD || rec_phase != PH_TRAIL)
            begin
                beat.record_status = STATUS_BAD;
            end
            else
            begin
                beat.record_status  = STATUS_OK;
                beat.sign_counter   = sign_word;
                beat.user_id_length = id_len;
            end
            owed_results.push_back(beat);
            clear_record();
        end
    endfunction

    // predict on accepted input beats, compare accepted result beats
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_record();
            owed_results.delete();
        end
        else
        begin
            if (byte_valid && byte_ready)
            begin
                parse_byte(byte_beat.record_byte, byte_beat.is_last);
            end
            if (result_valid && result_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("%0t: result beat with none pending: kind %0d sel %0d byte %02h",
                                 $time, result_beat.result_kind, result_beat.field_select,
                                 result_beat.payload_byte);
                    end
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (result_beat.result_kind !== want.result_kind ||
                        result_beat.field_select !== want.field_select ||
                        result_beat.payload_byte !== want.payload_byte ||
                        result_beat.record_status !== want.record_status ||
                        result_beat.sign_counter !== want.sign_counter ||
                        result_beat.user_id_length !== want.user_id_length)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("%0t: result mismatch, expected kind %0d sel %0d byte %02h",
                                     $time, want.result_kind, want.field_select,
                                     want.payload_byte);
                            $display("    status %0d count %08h id_len %0d",
                                     want.record_status, want.sign_counter,
                                     want.user_id_length);
                            $display("    got kind %0d sel %0d byte %02h status %0d",
                                     result_beat.result_kind, result_beat.field_select,
                                     result_beat.payload_byte, result_beat.record_status);
                            $display("    count %08h id_len %0d",
                                     result_beat.sign_counter, result_beat.user_id_length);
                        end
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
        end
        pending_results = owed_results.size();
    end

endmodule

@@ sim/tb_top.sv @@
// tb_top: drives credential records into the parser, stalls the result side
// and prints the verdict; depends on crp_pkg, crp_stream_if,
// credential_record_parser and crp_tb_checker
`timescale 1ns / 1ps

module tb_top;
    import crp_pkg::*;

    localparam int unsigned PARTY_NAME_MAX = 64;
    localparam int unsigned USER_NAME_MAX  = 64;
    localparam int unsigned USER_ID_MAX    = 64;
    localparam int          ITEM_BUDGET    = 1750;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          CYCLE_LIMIT    = 400000;

    // shape of one record to send
    typedef struct packed {
        int          magic_flaw;
        logic [7:0]  version;
        logic [31:0] count;
        logic [7:0]  len_party;
        logic [7:0]  len_user;
        logic [7:0]  len_id;
        int          trail;
        int          cut;
    } record_plan_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int mismatch_count;
    int pending_results;
    int cycle_count = 0;
    int bytes_sent  = 0;

    // receiver controls, each written by the stimulus process only
    int   hold_req  = 0;
    logic out_quiet = 1'b0;
    logic in_quiet  = 1'b0;

    crp_stream_if #(.payload_t(crp_in_t))  byte_stream ();
    crp_stream_if #(.payload_t(crp_out_t)) result_stream ();

    credential_record_parser #(
        .PARTY_NAME_MAX (PARTY_NAME_MAX),
        .USER_NAME_MAX  (USER_NAME_MAX),
        .USER_ID_MAX    (USER_ID_MAX)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_stream),
        .result_stream (result_stream)
    );

    crp_tb_checker #(
        .PARTY_NAME_MAX (PARTY_NAME_MAX),
        .USER_NAME_MAX  (USER_NAME_MAX),
        .USER_ID_MAX    (USER_ID_MAX)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_stream.valid),
        .byte_ready      (byte_stream.ready),
        .byte_beat       (byte_stream.payload),
        .result_valid    (result_stream.valid),
        .result_ready    (result_stream.ready),
        .result_beat     (result_stream.payload),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_stream.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n || hold_left > 0)
            begin
                result_stream.ready = 1'b0;
                if (hold_left > 0)
                begin
                    hold_left = hold_left - 1;
                end
            end
            else if (!out_quiet && $urandom_range(0, 99) < 16)
            begin
                result_stream.ready = 1'b0;
            end
            else
            begin
                result_stream.ready = 1'b1;
            end
        end
    end

    // idle cycle before the next input beat
    function automatic int idle_gap();
        if (in_quiet || $urandom_range(0, 99) >= 16)
        begin
            return 0;
        end
        return 1;
    endfunction

    // offer one byte at a falling edge and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_gap();
        repeat (gap)
        begin
            byte_stream.valid = 1'b0;
            @(negedge clk);
        end
        byte_stream.valid               = 1'b1;
        byte_stream.payload.record_byte = b;
        byte_stream.payload.is_last     = last;
        do
        begin
            @(posedge clk);
        end
        while (!byte_stream.ready);
        @(negedge clk);
    endtask

    // stop offering and wait until every owed result beat has come
    task automatic drain();
        byte_stream.valid = 1'b0;
        while (pending_results != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic record_plan_t make_plan(input int flaw, input logic [7:0] version,
                                               input logic [31:0] count,
                                               input logic [7:0] l0, input logic [7:0] l1,
                                               input logic [7:0] l2, input int trail,
                                               input int cut);
        record_plan_t plan;
        plan.magic_flaw = flaw;
        plan.version    = version;
        plan.count      = count;
        plan.len_party  = l0;
        plan.len_user   = l1;
        plan.len_id     = l2;
        plan.trail      = trail;
        plan.cut        = cut;
        return plan;
    endfunction

    // field length: mostly short, sometimes zero, sometimes up to the bound
    function automatic logic [7:0] pick_len(input int max_ok);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return 8'd0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 6);
        end
        return $urandom_range(max_ok - 3, max_ok);
    endfunction

    // mostly well-formed records with random content, the rest broken or noise
    function automatic record_plan_t random_plan();
        record_plan_t plan;
        int           kind;
        plan = make_plan(-1, RECORD_VERSION, $urandom, pick_len(PARTY_NAME_MAX - 1),
                         pick_len(USER_NAME_MAX - 1), pick_len(USER_ID_MAX),
                         ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0, 0);
        kind = $urandom_range(0, 99);
        if (kind < 68)
        begin
        end
        else if (kind < 74)
        begin
            plan.magic_flaw = $urandom_range(0, 3);
        end
        else if (kind < 78)
        begin
            plan.version = $urandom_range(0, 255);
            if (plan.version == RECORD_VERSION)
            begin
                plan.version = 8'd0;
            end
        end
        else if (kind < 81)
        begin
            plan.len_party = $urandom_range(PARTY_NAME_MAX, 255);
        end
        else if (kind < 84)
        begin
            plan.len_user = $urandom_range(USER_NAME_MAX, 255);
        end
        else if (kind < 87)
        begin
            plan.len_id = $urandom_range(USER_ID_MAX + 1, 255);
        end
        else if (kind < 96)
        begin
            plan.cut = $urandom_range(1, 100);
        end
        else
        begin
            plan.magic_flaw = int'($urandom_range(0, 4)) - 1;
            plan.cut        = $urandom_range(1, 12);
        end
        return plan;
    endfunction

    // lay out one record and send it, the last sent byte flagged
    task automatic send_record(input record_plan_t plan);
        logic [7:0]  rec[$];
        logic [7:0]  lens[3];
        logic [7:0]  flip;
        logic [31:0] magic_word;
        int          n;
        int          sent;
        magic_word = RECORD_MAGIC;
        lens[0]    = plan.len_party;
        lens[1]    = plan.len_user;
        lens[2]    = plan.len_id;
        // header: magic, version, ignored byte, sign count, key and hash
        for (int i = 0; i < 4; i++)
        begin
            flip = (i == plan.magic_flaw) ? $urandom_range(1, 255) : 0;
            rec.push_back(magic_word[8 * i +: 8] ^ flip);
        end
        rec.push_back(plan.version);
        rec.push_back($urandom);
        for (int i = 0; i < 4; i++)
        begin
            rec.push_back(plan.count[8 * i +: 8]);
        end
        for (int i = 0; i < 64; i++)
        begin
            rec.push_back($urandom);
        end
        // length-prefixed fields, trimmed when the length is far out of range
        for (int f = 0; f < 3; f++)
        begin
            rec.push_back(lens[f]);
            n = (lens[f] > 80) ? 8 : lens[f];
            for (int i = 0; i < n; i++)
            begin
                rec.push_back($urandom);
            end
        end
        for (int i = 0; i < plan.trail; i++)
        begin
            rec.push_back($urandom);
        end
        sent = (plan.cut > 0 && plan.cut < rec.size()) ? plan.cut : rec.size();
        for (int i = 0; i < sent; i++)
        begin
            send_byte(rec[i], i == sent - 1);
        end
        bytes_sent = bytes_sent + sent;
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        byte_stream.valid               = 1'b0;
        byte_stream.payload.record_byte = 8'd0;
        byte_stream.payload.is_last     = 1'b0;
        repeat (4)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;
        @(negedge clk);

        // directed records
        // shortest good record, all fields empty, zero count
        send_record(make_plan(-1, RECORD_VERSION, 32'h0, 8'd0, 8'd0, 8'd0, 0, 0));
        // widest fields, full count, trailing bytes; result side holds off meanwhile
        hold_req = hold_req + 1;
        send_record(make_plan(-1, RECORD_VERSION, 32'hffff_ffff, 8'd63, 8'd63, 8'd64, 3, 0));
        // bad magic in first and last magic byte
        send_record(make_plan(0, RECORD_VERSION, 32'h1234_5678, 8'd2, 8'd2, 8'd2, 0, 0));
        send_record(make_plan(3, RECORD_VERSION, 32'h0bad_0bad, 8'd2, 8'd2, 8'd2, 0, 0));
        // bad version, low and high
        send_record(make_plan(-1, 8'h00, 32'h1, 8'd1, 8'd1, 8'd1, 0, 0));
        send_record(make_plan(-1, 8'hff, 32'h2, 8'd1, 8'd1, 8'd1, 0, 0));
        // lengths at and past their bounds, rest of the record cut short or trimmed
        send_record(make_plan(-1, RECORD_VERSION, 32'h3, 8'd64, 8'd1, 8'd1, 0, 90));
        send_record(make_plan(-1, RECORD_VERSION, 32'h4, 8'd1, 8'd64, 8'd1, 0, 90));
        send_record(make_plan(-1, RECORD_VERSION, 32'h5, 8'd1, 8'd1, 8'd65, 0, 90));
        send_record(make_plan(-1, RECORD_VERSION, 32'h6, 8'd0, 8'd0, 8'd255, 0, 0));
        // no idling on either side for a stretch
        in_quiet  = 1'b1;
        out_quiet = 1'b1;
        // ends right before the first length byte
        send_record(make_plan(-1, RECORD_VERSION, 32'h7, 8'd5, 8'd5, 8'd5, 0, 74));
        // ends inside the user name
        send_record(make_plan(-1, RECORD_VERSION, 32'h8, 8'd5, 8'd5, 8'd5, 0, 83));
        // ends before the identifier length, long enough
        send_record(make_plan(-1, RECORD_VERSION, 32'h9, 8'd5, 8'd5, 8'd5, 0, 86));
        // single byte record
        send_record(make_plan(-1, RECORD_VERSION, 32'ha, 8'd0, 8'd0, 8'd0, 0, 1));
        // long tail past the saturating position
        send_record(make_plan(-1, RECORD_VERSION, 32'h8765_4321, 8'd3, 8'd0, 8'd7, 40, 0));
        // last byte closes the identifier: payload and summary together
        send_record(make_plan(-1, RECORD_VERSION, $urandom, 8'd1, 8'd2, 8'd64, 0, 0));
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
        drain();

        // random records
        while (bytes_sent < ITEM_BUDGET)
        begin
            send_record(random_plan());
        end
        drain();
        repeat (10)
        begin
            @(negedge clk);
        end

        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/crp_pkg.sv
rtl/core/crp_stream_if.sv
rtl/core/crp_parse_core.sv
rtl/core/crp_result_fifo.sv
rtl/core/credential_record_parser.sv
sim/crp_tb_checker.sv
sim/tb_top.sv
